// ===== rtl/gga_sentence_field_extractor_defines.svh =====
// Shared assertion macros for the GGA extractor checker.
`ifndef GGA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH
`define GGA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gse_pkg.sv =====
`default_nettype none

package gse_pkg;

    localparam int unsigned HEADER_LEN = 6;
    localparam logic [3:0]  ALT_COMMA  = 4'd9;
    localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
    localparam logic [7:0]  CHAR_DOLLAR = 8'h24;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] TAG_LAT = 3'd0;
    localparam logic [2:0] TAG_NS  = 3'd1;
    localparam logic [2:0] TAG_LON = 3'd2;
    localparam logic [2:0] TAG_EW  = 3'd3;
    localparam logic [2:0] TAG_ALT = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_HEADER = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [2:0] tag;
        logic [3:0] idx;
        logic [7:0] chr;
        logic [1:0] status;
        logic       last;
    } gse_result_t;

    typedef struct packed {
        logic v0;
        logic v1;
    } gse_push_t;

    // "$GPGGA", one character per match position.
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gse_parser.sv =====
`default_nettype none

module gse_parser #(
    parameter int LAT_MAX_CHARS = 9,
    parameter int LON_MAX_CHARS = 10,
    parameter int ALT_MAX_CHARS = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  wire  [7:0]           rx_byte,
    input  wire                  frame_end,
    output gse_pkg::gse_push_t   push,
    output gse_pkg::gse_result_t d0,
    output gse_pkg::gse_result_t d1
);

    logic [2:0] match_reg, match_next;
    logic       found_reg, found_next;
    logic [3:0] comma_reg, comma_next;
    logic [3:0] fcnt_reg,  fcnt_next;
    logic       alt_reg,   alt_next;
    logic       done_reg,  done_next;

    logic       char_v;
    logic [2:0] m;
    logic       fld_v;
    logic [2:0] fld_tag;
    logic [3:0] fld_max;
    logic [1:0] status;
    gse_pkg::gse_result_t char_item;
    gse_pkg::gse_result_t stat_item;

    // Field after comma number comma_reg: tag and capture limit.
    always_comb
    begin
        fld_v   = 1'b1;
        fld_tag = gse_pkg::TAG_LAT;
        fld_max = 4'(LAT_MAX_CHARS);
        unique case (comma_reg)
            4'd2: begin fld_tag = gse_pkg::TAG_LAT; fld_max = 4'(LAT_MAX_CHARS); end
            4'd3: begin fld_tag = gse_pkg::TAG_NS;  fld_max = 4'd1;              end
            4'd4: begin fld_tag = gse_pkg::TAG_LON; fld_max = 4'(LON_MAX_CHARS); end
            4'd5: begin fld_tag = gse_pkg::TAG_EW;  fld_max = 4'd1;              end
            4'd9: begin fld_tag = gse_pkg::TAG_ALT; fld_max = 4'(ALT_MAX_CHARS); end
            default: fld_v = 1'b0;
        endcase
    end

    always_comb
    begin
        match_next = match_reg;
        found_next = found_reg;
        comma_next = comma_reg;
        fcnt_next  = fcnt_reg;
        alt_next   = alt_reg;
        done_next  = done_reg;
        char_v     = 1'b0;
        m          = 3'd0;
        status     = gse_pkg::STATUS_OK;

        if (!found_reg) begin
            if (rx_byte == gse_pkg::header_char(match_reg)) begin
                m = match_reg + 3'd1;
            end else begin
                m = (rx_byte == gse_pkg::CHAR_DOLLAR) ? 3'd1 : 3'd0;
            end
            if (m == 3'(gse_pkg::HEADER_LEN)) begin
                found_next = 1'b1;
                match_next = 3'd0;
                comma_next = 4'd0;
                fcnt_next  = 4'd0;
            end else begin
                match_next = m;
            end
        end else if (!done_reg) begin
            if (comma_reg >= gse_pkg::ALT_COMMA) begin
                alt_next = 1'b1;
            end
            if (rx_byte == gse_pkg::CHAR_COMMA) begin
                if (comma_reg >= gse_pkg::ALT_COMMA) begin
                    done_next = 1'b1;
                end else begin
                    comma_next = comma_reg + 4'd1;
                    fcnt_next  = 4'd0;
                end
            end else if (fld_v && (fcnt_reg < fld_max)) begin
                char_v    = 1'b1;
                fcnt_next = fcnt_reg + 4'd1;
            end
        end

        // Status looks at the state after this byte; on frame end, drop back to hunting.
        if (!found_next) begin
            status = gse_pkg::STATUS_NO_HEADER;
        end else if (!alt_next) begin
            status = gse_pkg::STATUS_TRUNCATED;
        end
        if (frame_end) begin
            match_next = 3'd0;
            found_next = 1'b0;
            comma_next = 4'd0;
            fcnt_next  = 4'd0;
            alt_next   = 1'b0;
            done_next  = 1'b0;
        end
    end

    always_comb
    begin
        char_item        = '0;
        char_item.kind   = gse_pkg::KIND_CHAR;
        char_item.tag    = fld_tag;
        char_item.idx    = fcnt_reg;
        char_item.chr    = rx_byte;
        stat_item        = '0;
        stat_item.kind   = gse_pkg::KIND_STATUS;
        stat_item.status = status;
        stat_item.last   = 1'b1;

        // Pack results toward the first slot; a character goes first.
        push.v0 = accept && (char_v || frame_end);
        push.v1 = accept && char_v && frame_end;
        d0      = char_v ? char_item : stat_item;
        d1      = stat_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg <= 3'd0;
            found_reg <= 1'b0;
            comma_reg <= 4'd0;
            fcnt_reg  <= 4'd0;
            alt_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            match_reg <= match_next;
            found_reg <= found_next;
            comma_reg <= comma_next;
            fcnt_reg  <= fcnt_next;
            alt_reg   <= alt_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gse_result_queue.sv =====
`default_nettype none

module gse_result_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  gse_pkg::gse_push_t   push,
    input  gse_pkg::gse_result_t d0,
    input  gse_pkg::gse_result_t d1,
    output logic                 room,
    output logic                 out_valid,
    input  wire                  out_ready,
    output gse_pkg::gse_result_t q
);

    localparam int DEPTH = 4;

    gse_pkg::gse_result_t mem_reg [DEPTH];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [2:0] n_push;

    // Two free slots guarantee space for the worst-case beat pair.
    assign room      = (count_reg <= 3'(DEPTH - 2));
    assign out_valid = (count_reg != 3'd0);
    assign q         = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {2'b00, push.v0} + {2'b00, push.v1};

    always_comb
    begin
        wptr_next  = wptr_reg + n_push[1:0];
        rptr_next  = rptr_reg + {1'b0, pop};
        count_next = count_reg + n_push - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0) begin
            mem_reg[wptr_reg] <= d0;
        end
        if (push.v1) begin
            mem_reg[wptr_reg + 2'd1] <= d1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gga_sentence_field_extractor.sv =====
// GGA sentence field extractor.
// Input channel (in_valid/in_ready): one beat per received byte, rx_byte plus
// frame_end, which is high on the last byte of a capture frame.
// Output channel (out_valid/out_ready): character beats (item_kind 0) carry the
// field tag, the position in the field and the character for latitude,
// north/south, longitude, east/west and altitude; one status beat
// (item_kind 1, last_of_frame 1) closes each frame with ok, no header or
// truncated.
// Results are registered into the result queue as their byte is accepted and
// are offered in order. Throughput: one byte per cycle while in_ready is high.
// A byte yields zero, one or two beats; the two-beat case (captured character
// on the frame's last byte) leaves the result queue's single output port one
// beat at a time. The parse state is registered from each accepted byte;
// results go to a four-entry queue, and in_ready stays high while two entries
// are free, so up to two waiting results never block the next byte.
// Reset: parse state clears to hunting for the header, the queue empties.
// When the receiver stalls, results hold in the queue; once it has fewer than
// two free entries, in_ready drops until beats drain.
`default_nettype none

module gga_sentence_field_extractor #(
    parameter int LAT_MAX_CHARS = 9,
    parameter int LON_MAX_CHARS = 10,
    parameter int ALT_MAX_CHARS = 9
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] rx_byte,
    input  wire        frame_end,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       item_kind,
    output logic [2:0] field_tag,
    output logic [3:0] char_index,
    output logic [7:0] char_value,
    output logic [1:0] frame_status,
    output logic       last_of_frame
);

    logic                 accept;
    gse_pkg::gse_push_t   push;
    gse_pkg::gse_result_t d0;
    gse_pkg::gse_result_t d1;
    gse_pkg::gse_result_t q;

    // Take a byte whenever the queue can absorb its worst-case two beats.
    assign accept = in_valid && in_ready;

    gse_parser #(
        .LAT_MAX_CHARS (LAT_MAX_CHARS),
        .LON_MAX_CHARS (LON_MAX_CHARS),
        .ALT_MAX_CHARS (ALT_MAX_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .push      (push),
        .d0        (d0),
        .d1        (d1)
    );

    gse_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .d0        (d0),
        .d1        (d1),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .q         (q)
    );

    // Unpack the head entry onto the result ports.
    assign item_kind     = q.kind;
    assign field_tag     = q.tag;
    assign char_index    = q.idx;
    assign char_value    = q.chr;
    assign frame_status  = q.status;
    assign last_of_frame = q.last;

endmodule

`default_nettype wire

// ===== rtl/gse_checker.sv =====
`default_nettype none
`include "gga_sentence_field_extractor_defines.svh"

module gse_port_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire [7:0] rx_byte,
    input wire       frame_end,
    input wire       out_valid,
    input wire       out_ready,
    input wire       item_kind,
    input wire [2:0] field_tag,
    input wire [3:0] char_index,
    input wire [7:0] char_value,
    input wire [1:0] frame_status,
    input wire       last_of_frame
);

    `GSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(char_value) && $stable(item_kind),
        "output beat changed while stalled")
    `GSE_ASSERT_NOW(a_last_is_status, out_valid && last_of_frame,
        item_kind == gse_pkg::KIND_STATUS, "last_of_frame on a character beat")
    `GSE_ASSERT_NOW(a_char_fields, out_valid && item_kind == gse_pkg::KIND_CHAR,
        field_tag <= gse_pkg::TAG_ALT && frame_status == gse_pkg::STATUS_OK && !last_of_frame,
        "malformed character beat")
    `GSE_ASSERT_NEXT(a_frame_end_result, in_valid && in_ready && frame_end, out_valid,
        "no result after frame end byte")

endmodule

bind gga_sentence_field_extractor gse_port_checker u_gse_checker (.*);

`default_nettype wire

// ===== bench/gse_checker.sv =====
`default_nettype none

module gse_checker #(
    parameter int LAT_MAX_CHARS = 9,
    parameter int LON_MAX_CHARS = 10,
    parameter int ALT_MAX_CHARS = 9
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  wire  [7:0] rx_byte,
    input  wire        frame_end,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire        item_kind,
    input  wire  [2:0] field_tag,
    input  wire  [3:0] char_index,
    input  wire  [7:0] char_value,
    input  wire  [1:0] frame_status,
    input  wire        last_of_frame,
    output int         fail_count,
    output int         pending_beats,
    output int         checked_beats
);

    localparam logic [47:0] GGA_HEADER = "$GPGGA";
    localparam logic [3:0]  LAT_COMMA  = 4'd2;
    localparam logic [3:0]  NS_COMMA   = 4'd3;
    localparam logic [3:0]  LON_COMMA  = 4'd4;
    localparam logic [3:0]  EW_COMMA   = 4'd5;

    // Parse state of the predicted block.
    int unsigned  hdr_matched;
    bit           in_sentence;
    logic [3:0]   commas;
    logic [3:0]   field_len;
    bit           alt_seen;
    bit           alt_closed;

    gse_pkg::gse_result_t  expected_beats[$];

    function automatic bit captured_field(input logic [3:0] c, output logic [2:0] tag,
                                          output logic [3:0] limit);
        bit hit;
        hit = 1'b1;
        tag = gse_pkg::TAG_LAT;
        limit = '0;
        case (c)
            LAT_COMMA: begin tag = gse_pkg::TAG_LAT; limit = 4'(LAT_MAX_CHARS); end
            NS_COMMA:  begin tag = gse_pkg::TAG_NS;  limit = 4'd1; end
            LON_COMMA: begin tag = gse_pkg::TAG_LON; limit = 4'(LON_MAX_CHARS); end
            EW_COMMA:  begin tag = gse_pkg::TAG_EW;  limit = 4'd1; end
            gse_pkg::ALT_COMMA: begin tag = gse_pkg::TAG_ALT; limit = 4'(ALT_MAX_CHARS); end
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic clear_parse();
        hdr_matched = 0;
        in_sentence = 1'b0;
        commas      = '0;
        field_len   = '0;
        alt_seen    = 1'b0;
        alt_closed  = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fe);
        int unsigned m;
        logic [2:0]  tag;
        logic [3:0]  limit;
        gse_pkg::gse_result_t r;
        if (!in_sentence)
        begin
            m = hdr_matched;
            if (m < gse_pkg::HEADER_LEN && b == GGA_HEADER[47 - 8 * m -: 8])
                m++;
            else
                m = (b == gse_pkg::CHAR_DOLLAR) ? 1 : 0;
            if (m >= gse_pkg::HEADER_LEN)
            begin
                in_sentence = 1'b1;
                hdr_matched = 0;
                commas      = '0;
                field_len   = '0;
            end
            else
                hdr_matched = m;
        end
        else if (!alt_closed)
        begin
            if (commas >= gse_pkg::ALT_COMMA)
                alt_seen = 1'b1;
            if (b == gse_pkg::CHAR_COMMA)
            begin
                if (commas >= gse_pkg::ALT_COMMA)
                    alt_closed = 1'b1;
                else
                begin
                    commas++;
                    field_len = '0;
                end
            end
            else if (captured_field(commas, tag, limit) && field_len < limit)
            begin
                r        = '0;
                r.kind   = gse_pkg::KIND_CHAR;
                r.tag    = tag;
                r.idx    = field_len;
                r.chr    = b;
                r.status = gse_pkg::STATUS_OK;
                r.last   = 1'b0;
                expected_beats.push_back(r);
                field_len++;
            end
        end
        if (fe)
        begin
            r      = '0;
            r.kind = gse_pkg::KIND_STATUS;
            r.last = 1'b1;
            if (!in_sentence)
                r.status = gse_pkg::STATUS_NO_HEADER;
            else if (!alt_seen)
                r.status = gse_pkg::STATUS_TRUNCATED;
            else
                r.status = gse_pkg::STATUS_OK;
            expected_beats.push_back(r);
            clear_parse();
        end
    endtask

    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : check_beats
        gse_pkg::gse_result_t oldest;
        int          bad;
        if (!rst_n)
        begin
            clear_parse();
            expected_beats.delete();
            fail_count    <= 0;
            pending_beats <= 0;
            checked_beats <= 0;
        end
        else
        begin
            bad = 0;
            // Results are registered, so none leaves in the same cycle as its byte: compare before predicting.
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d tag %0d idx %0d",
                           item_kind, field_tag, char_index);
                    bad = 1;
                end
                else
                begin
                    oldest = expected_beats.pop_front();
                    bad += field_differs("item_kind", 8'(oldest.kind), 8'(item_kind));
                    bad += field_differs("field_tag", 8'(oldest.tag), 8'(field_tag));
                    bad += field_differs("char_index", 8'(oldest.idx), 8'(char_index));
                    bad += field_differs("char_value", oldest.chr, char_value);
                    bad += field_differs("frame_status", 8'(oldest.status),
                                         8'(frame_status));
                    bad += field_differs("last_of_frame", 8'(oldest.last),
                                         8'(last_of_frame));
                end
                checked_beats <= checked_beats + 1;
            end
            if (in_valid && in_ready)
                predict_byte(rx_byte, frame_end);
            if (bad != 0)
                fail_count <= fail_count + 1;
            pending_beats <= expected_beats.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

    // Idling phases, cycled frame by frame.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either channel
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int TARGET_BYTES  = 1025;
    localparam int DRAIN_CYCLES  = 10;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte       = '0;
    logic       frame_end     = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic       item_kind;
    logic [2:0] field_tag;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic [1:0] frame_status;
    logic       last_of_frame;

    int fail_count;
    int pending_beats;
    int checked_beats;

    idle_mode_t idle_mode    = IDLE_NONE;
    bit         hold_request = 1'b0;
    bit [7:0]   frame_q[$];
    int         bytes_sent   = 0;
    int         frames_sent  = 0;
    string      digits       = "0123456789.";

    always #5 clk = ~clk;

    gga_sentence_field_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .field_tag     (field_tag),
        .char_index    (char_index),
        .char_value    (char_value),
        .frame_status  (frame_status),
        .last_of_frame (last_of_frame)
    );

    gse_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .field_tag     (field_tag),
        .char_index    (char_index),
        .char_value    (char_value),
        .frame_status  (frame_status),
        .last_of_frame (last_of_frame),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .checked_beats (checked_beats)
    );

    function automatic int sender_idle_pct();
        return (idle_mode == IDLE_SENDER) ? 59 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_mode == IDLE_RECEIVER) ? 59 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    endfunction

    // Offer one byte; idle first if the phase asks, then hold until accepted.
    task automatic send_byte(input bit [7:0] b, input bit fe);
        while ($urandom_range(99) < sender_idle_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= fe;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the whole frame buffer, flagging frame end on its last byte.
    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            frame_q.push_back(s[i]);
    endtask

    // Mostly digits and dots, now and then any byte but a comma.
    task automatic push_field(input int len);
        bit [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(7) == 0)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == gse_pkg::CHAR_COMMA);
            end
            else
                b = digits[$urandom_range(10)];
            frame_q.push_back(b);
        end
    endtask

    task automatic push_noise(input int len);
        for (int i = 0; i < len; i++)
            frame_q.push_back(8'($urandom_range(255)));
    endtask

    // One GGA sentence with random field lengths, some beyond each field's limit.
    task automatic push_sentence();
        push_text("$GPGGA");
        if ($urandom_range(4) == 0)
            push_field($urandom_range(1, 2));      // junk before the first comma
        push_text(",");
        push_field($urandom_range(0, 4));          // time
        push_text(",");
        push_field($urandom_range(0, 11));         // latitude
        push_text(",");
        push_field($urandom_range(0, 2));          // north/south
        push_text(",");
        push_field($urandom_range(0, 12));         // longitude
        push_text(",");
        push_field($urandom_range(0, 2));          // east/west
        for (int k = 0; k < 3; k++)
        begin
            push_text(",");
            push_field($urandom_range(0, 4));      // fix, satellites, HDOP
        end
        push_text(",");
        push_field($urandom_range(0, 11));         // altitude
        if ($urandom_range(3) != 0)
            push_text(",M,-34.2,M,,*4F\r\n");
    endtask

    // Build one random frame: mostly well-formed, the rest noise or broken.
    task automatic build_frame();
        int pick;
        int cut;
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick < 10)
            push_noise($urandom_range(1, 20));
        else
        begin
            case ($urandom_range(3))
                0: push_noise($urandom_range(1, 5));
                1: push_text("$GPGG");             // restarted header
                2: push_text("$GP");
                default: ;
            endcase
            push_sentence();
            if ($urandom_range(3) == 0)
                push_sentence();                   // later header is plain data
            if (pick < 25)
            begin
                cut = $urandom_range(1, frame_q.size());
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
    endtask

    // Receiver: stall at the phase's rate; on request, hold off for a long stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            out_ready <= ($urandom_range(99) < receiver_stall_pct()) ? 1'b0 : 1'b1;
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int frame_no;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone non-header byte, header on the last byte,
        // restarted header with empty fields and a one-byte altitude ending the frame.
        frame_q = '{8'hFF};
        send_frame();
        frame_q.delete();
        push_text("$GPGGA");
        send_frame();
        frame_q.delete();
        push_text("$G$GPGGA,,,,,,,,,X");
        send_frame();

        // Random frames, rotating through the idling phases.
        frame_no = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            idle_mode = idle_mode_t'(frame_no % 4);
            // Stall the receiver at full input rate so the block backs up.
            if (frame_no == 4)
                hold_request = 1'b1;
            build_frame();
            send_frame();
            frame_no++;
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected beat, then let stray beats show up.
        do
            @(posedge clk);
        while (pending_beats != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d frames under four idling phases and one long hold-off",
                 bytes_sent, frames_sent);
        $display("checked %0d result beats", checked_beats);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
